// ===== rtl/core/ile_pkg.sv =====
`default_nettype none

package ile_pkg;

   localparam int POS_W  = 5;
   localparam int DATA_W = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_ERASE  = 1'b1
   } op_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic              shift_up;
      logic              shift_down;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/ile_req_if.sv =====
`default_nettype none

interface ile_req_if;
   logic                              valid;
   logic                              ready;
   logic                              req_type;
   logic [ile_pkg::POS_W-1:0]         position;
   logic signed [ile_pkg::DATA_W-1:0] item_value;

   modport source (output valid, output req_type, output position, output item_value,
                   input ready);
   modport sink   (input valid, input req_type, input position, input item_value,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ile_rsp_if.sv =====
`default_nettype none

interface ile_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      accepted;
   logic [ile_pkg::POS_W-1:0] count_after;

   modport source (output valid, output accepted, output count_after, input ready);
   modport sink   (input valid, input accepted, input count_after, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ile_cell.sv =====
`default_nettype none

module ile_cell #(
   parameter int IDX_W = 4,
   parameter int INDEX = 0
) (
   input  wire logic                         clock,
   input  wire ile_pkg::cell_ctl_type        ctl,
   input  wire logic [ile_pkg::DATA_W-1:0]   from_below,
   input  wire logic [ile_pkg::DATA_W-1:0]   from_above,
   output logic      [ile_pkg::DATA_W-1:0]   data_q
);

   localparam int CMP_W = (IDX_W > ile_pkg::POS_W) ? IDX_W : ile_pkg::POS_W;
   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

   logic [ile_pkg::DATA_W-1:0] data_ff;
   logic [ile_pkg::DATA_W-1:0] data_in;
   logic [CMP_W-1:0]           pos_ext;
   logic                       at_or_above;
   logic                       at_pos;

   assign pos_ext     = CMP_W'(ctl.pos);
   assign at_or_above = (MY_IDX >= pos_ext);
   assign at_pos      = (MY_IDX == pos_ext);

   always_comb begin
      data_in = data_ff;
      if (ctl.shift_up && at_or_above) begin
         data_in = at_pos ? ctl.value : from_below;
      end else if (ctl.shift_down && at_or_above) begin
         data_in = from_above;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/indexed_list_insert_erase.sv =====
`default_nettype none

// channel   | dir | handshake      | payload
// ----------+-----+----------------+-------------------------------------------
// req_ch    | in  | valid / ready  | req_type (0 insert, 1 erase), position,
//           |     |                | item_value (signed 32)
// rsp_ch    | out | valid / ready  | accepted, count_after
//
// one item per cycle while req_ch.ready is high: every cell of the chain moves
// its entry in the same cycle, so an insert or erase finishes at the accepting
// edge; the response shows in the next cycle from the output register.
// reset (synchronous, active high) clears the length and the response valid;
// entries hold garbage until written and need no clearing.
// req_ch.ready drops only while a response waits and rsp_ch.ready is low.

module indexed_list_insert_erase #(
   parameter int CAPACITY = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ile_req_if.sink    req_ch,
   ile_rsp_if.source  rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   // list length and response register
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      rsp_accepted_ff;
   logic                      rsp_accepted_in;
   logic [ile_pkg::POS_W-1:0] rsp_count_ff;
   logic [ile_pkg::POS_W-1:0] rsp_count_in;

   logic                      req_fire;
   logic                      is_erase;
   logic [CMP_W-1:0]          pos_ext;
   logic [CMP_W-1:0]          cnt_ext;
   logic                      insert_ok;
   logic                      erase_ok;
   ile_pkg::cell_ctl_type     ctl;

   logic [ile_pkg::DATA_W-1:0] cell_q [CAPACITY];

   // a new item is taken whenever the response slot is free or being drained
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign is_erase = (ile_pkg::op_type'(req_ch.req_type) == ile_pkg::OP_ERASE);
   assign pos_ext  = CMP_W'(req_ch.position);
   assign cnt_ext  = CMP_W'(count_ff);

   // insert fits when the slot is inside or right past the list and room is left
   assign insert_ok = !is_erase && (pos_ext <= cnt_ext) && (count_ff != CNT_FULL);
   // erase needs an existing entry
   assign erase_ok  = is_erase && (pos_ext < cnt_ext);

   always_comb begin
      ctl.shift_up   = req_fire && insert_ok;
      ctl.shift_down = req_fire && erase_ok;
      ctl.pos        = req_ch.position;
      ctl.value      = req_ch.item_value;
   end

   // chain of cells, each one entry wide
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ile_pkg::DATA_W-1:0] below;
      logic [ile_pkg::DATA_W-1:0] above;

      if (i == 0) begin : g_first
         assign below = '0;
      end else begin : g_mid_lo
         assign below = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign above = '0;
      end else begin : g_mid_hi
         assign above = cell_q[i+1];
      end

      ile_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .from_below (below),
         .from_above (above),
         .data_q     (cell_q[i])
      );
   end

   // next length and response
   always_comb begin
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_count_in    = rsp_count_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         priority if (ctl.shift_up) begin
            count_in = count_ff + CNT_W'(1);
         end else if (ctl.shift_down) begin
            count_in = count_ff - CNT_W'(1);
         end else begin
            // rejected item keeps the length
            count_in = count_ff;
         end
         rsp_valid_in    = 1'b1;
         rsp_accepted_in = ctl.shift_up || ctl.shift_down;
         // length reported on 5 bits, upper bits dropped for large lists
         rsp_count_in    = ile_pkg::POS_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.accepted    = rsp_accepted_ff;
   assign rsp_ch.count_after = rsp_count_ff;

   // length never passes the capacity
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("list length above capacity");

   // every accepted item leaves a response behind
   a_fire_rsp : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("no response after accepted item");

   // a rejected item leaves the length alone
   a_reject_hold : assert property (@(posedge clock) disable iff (reset)
      req_fire && !insert_ok && !erase_ok |=> $stable(count_ff) && !rsp_accepted_ff)
      else $error("rejected item changed the length");

   // accepted insert grows the list by one and reports it
   a_insert_grow : assert property (@(posedge clock) disable iff (reset)
      req_fire && insert_ok |=> (count_ff == $past(count_ff) + CNT_W'(1)) && rsp_accepted_ff)
      else $error("insert did not grow the list");

endmodule

`default_nettype wire
